### src/i4dl_pkg.sv
// ----------------------------------------------------------------------------
// i4dl_pkg
// Shared constants and small helpers for the INT4 dequantising L2 distance unit.
// ----------------------------------------------------------------------------
package i4dl_pkg;

  typedef logic [3:0] nibble_t;

  localparam logic [63:0] SUM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  // Largest magnitude whose square still fits below SUM_MAX
  localparam logic [63:0] ROOT_MAX = 64'd3037000499;
  // Multiplicative inverse of 15 modulo 2^32 (exact division by 15)
  localparam logic [31:0] INV15    = 32'hEEEE_EEEF;
  localparam nibble_t     NIB_MASK = 4'hF;

  // Remainder by 15 of a nibble sum (at most 8 nibbles, so below 121)
  function automatic nibble_t mod15_small(input logic [6:0] s);
    logic [6:0] r;
    r = s;
    for (int k = 1; k <= 8; k++) begin
      if (s >= 7'(15 * k)) r = s - 7'(15 * k);
    end
    return r[3:0];
  endfunction

  // Quotient by 15 of a code times remainder (at most 225)
  function automatic nibble_t div15_small(input logic [7:0] x);
    nibble_t q;
    q = '0;
    for (int k = 1; k <= 15; k++) begin
      if (x >= 8'(15 * k)) q = 4'(k);
    end
    return q;
  endfunction

endpackage

### src/int4_dequant_l2_distance_unit.sv
// ----------------------------------------------------------------------------
// int4_dequant_l2_distance_unit
// Streaming squared L2 distance between a query and an INT4 packed code vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the request fields and raise push; a request is taken
//   on a rising edge with push high and full low. Each request holds one code
//   byte (high nibble = first dimension, low nibble = second, the latter only
//   when in_second_valid is set) plus query, min and diff per dimension.
//   A request with in_last set closes the vector: its distance is queued and
//   the running sum clears for the next vector.
//   Result queue: out_distance is valid while empty is low; raise pop to take
//   it. Results keep request order.
//   Throughput: one request per cycle, sustained unless the back end stalls.
//   The front stage and a 4-entry request queue decouple the input from a
//   6-stage back pipeline; only the final 64-bit saturating accumulate
//   carries state between items.
//   Stall: the back end issues only when the 16-entry result queue has a
//   slot reserved for every request in flight, so a stalled receiver fills
//   the result queue, then the request queue, then raises full.
//   Reset (synchronous, rst_n low): queues empty, sum zero.
// ----------------------------------------------------------------------------
module int4_dequant_l2_distance_unit #(
  parameter int VALUE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_code_byte,
  input  logic signed [VALUE_BITS-1:0] in_query_first,
  input  logic signed [VALUE_BITS-1:0] in_min_first,
  input  logic signed [VALUE_BITS-1:0] in_diff_first,
  input  logic signed [VALUE_BITS-1:0] in_query_second,
  input  logic signed [VALUE_BITS-1:0] in_min_second,
  input  logic signed [VALUE_BITS-1:0] in_diff_second,
  input  logic                         in_second_valid,
  input  logic                         in_last,
  output logic                         empty,
  input  logic                         pop,
  output logic [62:0]                  out_distance
);

  localparam int IW        = 6*VALUE_BITS + 20;
  localparam int REQ_DEPTH = 4;
  localparam int OUT_DEPTH = 16;

  logic [IW-1:0]                  front_item;
  logic [IW-1:0]                  q_item;
  logic                           q_empty;
  logic                           q_pop;
  logic [$clog2(REQ_DEPTH):0]     q_count;
  logic [$clog2(OUT_DEPTH):0]     res_count;
  logic                           res_push;
  logic [62:0]                    res_data;
  logic                           res_full;

  // Front: split the byte and reduce |diff| mod 15 ahead of the queue
  i4dl_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .code_byte    (in_code_byte),
    .query_first  (in_query_first),
    .min_first    (in_min_first),
    .diff_first   (in_diff_first),
    .query_second (in_query_second),
    .min_second   (in_min_second),
    .diff_second  (in_diff_second),
    .second_valid (in_second_valid),
    .last         (in_last),
    .item         (front_item)
  );

  // Request queue between front and back
  i4dl_fifo #(.WIDTH(IW), .DEPTH(REQ_DEPTH)) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty),
    .count (q_count)
  );

  // Back: dequantise, square, accumulate
  i4dl_back #(.VALUE_BITS(VALUE_BITS), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_empty (q_empty | (q_count == '0)),
    .item_pop   (q_pop),
    .out_count  (res_count),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // Result queue; slots are reserved upstream, so it never overflows
  i4dl_fifo #(.WIDTH(63), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push & ~res_full),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_distance),
    .empty (empty),
    .count (res_count)
  );

endmodule

### src/i4dl_fifo.sv
// ----------------------------------------------------------------------------
// i4dl_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module i4dl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign count   = wr_ptr_r - rd_ptr_r;
  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r[AW-1:0]];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r[AW-1:0]] <= wdata;
  end

endmodule

### src/i4dl_front.sv
// ----------------------------------------------------------------------------
// i4dl_front
// Splits a request into two dimension records and pre-reduces |diff| mod 15.
// ----------------------------------------------------------------------------
module i4dl_front #(
  parameter int VALUE_BITS = 24
) (
  input  logic [7:0]                  code_byte,
  input  logic signed [VALUE_BITS-1:0] query_first,
  input  logic signed [VALUE_BITS-1:0] min_first,
  input  logic signed [VALUE_BITS-1:0] diff_first,
  input  logic signed [VALUE_BITS-1:0] query_second,
  input  logic signed [VALUE_BITS-1:0] min_second,
  input  logic signed [VALUE_BITS-1:0] diff_second,
  input  logic                        second_valid,
  input  logic                        last,
  output logic [6*VALUE_BITS+19:0]    item
);

  localparam int VB   = VALUE_BITS;
  localparam int DW   = 3*VB + 9;
  localparam int NNIB = (VB + 3) / 4;

  logic [DW-1:0] dim_a, dim_b;

  // Record: {code, diff sign, |diff|, |diff| mod 15, query, min}
  function automatic logic [DW-1:0] pack_dim(
    input i4dl_pkg::nibble_t     q,
    input logic signed [VB-1:0]  qv,
    input logic signed [VB-1:0]  mv,
    input logic signed [VB-1:0]  dv
  );
    logic                neg;
    logic [VB-1:0]       mag;
    logic [NNIB*4-1:0]   padded;
    logic [6:0]          nsum;
    neg    = dv[VB-1];
    mag    = neg ? VB'(-dv) : VB'(dv);
    padded = (NNIB*4)'(mag);
    nsum   = '0;
    // 16 = 1 mod 15, so the nibble sum keeps the remainder
    for (int n = 0; n < NNIB; n++) begin
      nsum = nsum + 7'(padded[n*4 +: 4]);
    end
    return {q, neg, mag, i4dl_pkg::mod15_small(nsum), qv, mv};
  endfunction

  always_comb begin
    dim_a = pack_dim(code_byte[7:4] & i4dl_pkg::NIB_MASK, query_first, min_first, diff_first);
    dim_b = pack_dim(code_byte[3:0] & i4dl_pkg::NIB_MASK, query_second, min_second,
                     diff_second);
  end

  assign item = {last, second_valid, dim_a, dim_b};

endmodule

### src/i4dl_term.sv
// ----------------------------------------------------------------------------
// i4dl_term
// Four-stage pipeline: dequantise one code, subtract from query, square.
// ----------------------------------------------------------------------------
module i4dl_term #(
  parameter int VALUE_BITS = 24
) (
  input  logic                         clk,
  input  i4dl_pkg::nibble_t            code,
  input  logic                         neg,
  input  logic [VALUE_BITS-1:0]        dmag,
  input  i4dl_pkg::nibble_t            rem,
  input  logic signed [VALUE_BITS-1:0] query,
  input  logic signed [VALUE_BITS-1:0] mn,
  output logic [63:0]                  sq
);

  localparam int VB  = VALUE_BITS;
  localparam int SQW = (VB + 2 > 32) ? 32 : VB + 2;

  // stage 2
  logic [VB-1:0]          a_r, a_nxt;
  i4dl_pkg::nibble_t      qbq_r, qbq_nxt;
  i4dl_pkg::nibble_t      code2_r;
  logic                   neg2_r;
  logic signed [VB:0]     qm2_r, qm2_nxt;
  // stage 3
  logic signed [VB:0]     sc3_r, sc3_nxt;
  logic signed [VB:0]     qm3_r;
  // stage 4
  logic [VB+1:0]          mag4_r, mag4_nxt;
  logic                   sat4_r, sat4_nxt;
  // stage 5
  logic [63:0]            sq_r, sq_nxt;

  logic [VB-1:0]          num;
  logic [2*VB-1:0]        prod;
  logic [7:0]             qb;
  logic [VB+3:0]          smag;
  logic [VB:0]            smag_u;
  logic signed [VB+1:0]   d;
  logic [SQW-1:0]         m;
  logic [2*SQW-1:0]       msq;

  always_comb begin
    // |diff| = 15*a + rem, so q*|diff|/15 = q*a + (q*rem)/15
    num      = dmag - VB'(rem);
    prod     = {{VB{1'b0}}, num} * {{VB{1'b0}}, i4dl_pkg::INV15[VB-1:0]};
    a_nxt    = prod[VB-1:0];
    qb       = 8'(code) * 8'(rem);
    qbq_nxt  = i4dl_pkg::div15_small(qb);
    qm2_nxt  = {query[VB-1], query} - {mn[VB-1], mn};

    smag     = (VB+4)'(code2_r) * (VB+4)'(a_r) + (VB+4)'(qbq_r);
    smag_u   = {1'b0, smag[VB-1:0]};
    sc3_nxt  = neg2_r ? -$signed(smag_u) : $signed(smag_u);

    d        = {qm3_r[VB], qm3_r} - {sc3_r[VB], sc3_r};
    mag4_nxt = d[VB+1] ? (VB+2)'(-d) : (VB+2)'(d);
    sat4_nxt = (64'(mag4_nxt) > i4dl_pkg::ROOT_MAX);

    m        = mag4_r[SQW-1:0];
    msq      = m * m;
    sq_nxt   = sat4_r ? i4dl_pkg::SUM_MAX : 64'(msq);
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    qbq_r   <= qbq_nxt;
    code2_r <= code;
    neg2_r  <= neg;
    qm2_r   <= qm2_nxt;
    sc3_r   <= sc3_nxt;
    qm3_r   <= qm2_r;
    mag4_r  <= mag4_nxt;
    sat4_r  <= sat4_nxt;
    sq_r    <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

### src/i4dl_back.sv
// ----------------------------------------------------------------------------
// i4dl_back
// Drains the request queue through two term pipelines and accumulates.
// ----------------------------------------------------------------------------
module i4dl_back #(
  parameter int VALUE_BITS = 24,
  parameter int OUT_DEPTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [6*VALUE_BITS+19:0]     item,
  input  logic                         item_empty,
  output logic                         item_pop,
  input  logic [$clog2(OUT_DEPTH):0]   out_count,
  output logic                         res_push,
  output logic [62:0]                  res_data
);

  localparam int VB = VALUE_BITS;
  localparam int IW = 6*VB + 20;
  localparam int DW = 3*VB + 9;
  localparam int CW = $clog2(OUT_DEPTH) + 1;

  logic [IW-1:0] item1_r;
  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic          l2_r, l3_r, l4_r, l5_r, l6_r;
  logic          s2_r, s3_r, s4_r, s5_r;
  logic [63:0]   t6_r, t6_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic [63:0]   sq_a, sq_b, sq_b_m, tsum, total, total_sat;
  logic [DW-1:0] dim_a, dim_b;
  logic [2:0]    inflight;
  logic [CW:0]   booked;

  // Every item in flight has a result slot reserved, so the pipe never stalls
  always_comb begin
    inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r) + 3'(v5_r) + 3'(v6_r);
    booked   = (CW+1)'(out_count) + (CW+1)'(inflight);
    item_pop = ~item_empty & (booked < (CW+1)'(OUT_DEPTH));
  end

  assign dim_a = item1_r[2*DW-1:DW];
  assign dim_b = item1_r[DW-1:0];

  i4dl_term #(.VALUE_BITS(VB)) u_term_a (
    .clk   (clk),
    .code  (dim_a[DW-1:DW-4]),
    .neg   (dim_a[DW-5]),
    .dmag  (dim_a[DW-6:2*VB+4]),
    .rem   (dim_a[2*VB+3:2*VB]),
    .query (dim_a[2*VB-1:VB]),
    .mn    (dim_a[VB-1:0]),
    .sq    (sq_a)
  );

  i4dl_term #(.VALUE_BITS(VB)) u_term_b (
    .clk   (clk),
    .code  (dim_b[DW-1:DW-4]),
    .neg   (dim_b[DW-5]),
    .dmag  (dim_b[DW-6:2*VB+4]),
    .rem   (dim_b[2*VB+3:2*VB]),
    .query (dim_b[2*VB-1:VB]),
    .mn    (dim_b[VB-1:0]),
    .sq    (sq_b)
  );

  always_comb begin
    sq_b_m    = s5_r ? sq_b : '0;
    tsum      = sq_a + sq_b_m;
    t6_nxt    = tsum[63] ? i4dl_pkg::SUM_MAX : tsum;
    total     = sum_r + t6_r;
    total_sat = total[63] ? i4dl_pkg::SUM_MAX : total;
    sum_nxt   = sum_r;
    if (v6_r) begin
      sum_nxt = l6_r ? '0 : total_sat;
    end
    res_push  = v6_r & l6_r;
    res_data  = total_sat[62:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      sum_r <= '0;
    end else begin
      v1_r  <= item_pop;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) item1_r <= item;
    l2_r <= item1_r[IW-1];
    s2_r <= item1_r[IW-2];
    l3_r <= l2_r;
    s3_r <= s2_r;
    l4_r <= l3_r;
    s4_r <= s3_r;
    l5_r <= l4_r;
    s5_r <= s4_r;
    l6_r <= l5_r;
    t6_r <= t6_nxt;
  end

endmodule

### test/int4_dequant_l2_distance_unit_test.sv
// ----------------------------------------------------------------------------
// int4_dequant_l2_distance_unit_test
// Drives packed INT4 code bytes through the unit and checks every distance.
// The scoreboard predicts each distance from the accepted requests, and every
// popped result is compared with the oldest prediction. The run covers
// directed corner cases, random vectors under three idling profiles and a
// long receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module int4_dequant_l2_distance_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 24;
  localparam logic signed [VB-1:0] V_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] V_MIN = {1'b1, {(VB-1){1'b0}}};

  // One request as the input queue sees it
  typedef struct {
    logic [7:0]           code;
    logic signed [VB-1:0] query_a;
    logic signed [VB-1:0] min_a;
    logic signed [VB-1:0] diff_a;
    logic signed [VB-1:0] query_b;
    logic signed [VB-1:0] min_b;
    logic signed [VB-1:0] diff_b;
    logic                 second_valid;
    logic                 last;
  } request_t;

  // Distance predictor and store of distances still owed by the unit
  class distance_scoreboard;
    localparam bit [63:0] SAT_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [63:0] ROOT_LIMIT = 64'd3037000499;

    bit [63:0] vector_sum;
    bit [62:0] owed_distances[$];
    int        errors;

    function new();
      vector_sum = '0;
      errors     = 0;
    endfunction

    // Squared gap between query and dequantised code for one dimension
    function bit [63:0] dim_square(bit [3:0] code, logic signed [VB-1:0] query,
                                   logic signed [VB-1:0] offset,
                                   logic signed [VB-1:0] range_v);
      longint    scaled;
      longint    gap;
      bit [63:0] mag;
      scaled = (longint'(code) * longint'(range_v)) / 15;  // truncates to zero
      gap    = longint'(query) - (longint'(offset) + scaled);
      mag    = (gap < 0) ? 64'(-gap) : 64'(gap);
      if (mag > ROOT_LIMIT) return SAT_LIMIT;
      return mag * mag;
    endfunction

    function void add_square(bit [63:0] sq);
      bit [64:0] s;
      s = {1'b0, vector_sum} + {1'b0, sq};
      vector_sum = (s > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : s[63:0];
    endfunction

    function void note_request(request_t r);
      add_square(dim_square(r.code[7:4], r.query_a, r.min_a, r.diff_a));
      if (r.second_valid)
        add_square(dim_square(r.code[3:0], r.query_b, r.min_b, r.diff_b));
      if (r.last) begin
        owed_distances.push_back(vector_sum[62:0]);
        vector_sum = '0;
      end
    endfunction

    function void check_distance(bit [62:0] got);
      bit [62:0] want;
      if (owed_distances.size() == 0) begin
        $display("%0t: distance %h with none expected", $time, got);
        errors++;
        return;
      end
      want = owed_distances.pop_front();
      if (got !== want) begin
        $display("%0t: distance mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int owed();
      return owed_distances.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic [7:0]           in_code_byte;
  logic signed [VB-1:0] in_query_first;
  logic signed [VB-1:0] in_min_first;
  logic signed [VB-1:0] in_diff_first;
  logic signed [VB-1:0] in_query_second;
  logic signed [VB-1:0] in_min_second;
  logic signed [VB-1:0] in_diff_second;
  logic                 in_second_valid;
  logic                 in_last;
  logic                 empty;
  logic                 pop;
  logic [62:0]          out_distance;

  distance_scoreboard sb;

  // Idling profile, shared by the sender task and the receiver process
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_off_req;

  int4_dequant_l2_distance_unit #(.VALUE_BITS(VB)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_code_byte    (in_code_byte),
    .in_query_first  (in_query_first),
    .in_min_first    (in_min_first),
    .in_diff_first   (in_diff_first),
    .in_query_second (in_query_second),
    .in_min_second   (in_min_second),
    .in_diff_second  (in_diff_second),
    .in_second_valid (in_second_valid),
    .in_last         (in_last),
    .empty           (empty),
    .pop             (pop),
    .out_distance    (out_distance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the unit hangs
  initial begin
    #10ms;
    $display("int4_dequant_l2_distance_unit test failed");
    $finish;
  end

  function automatic request_t mk(logic [7:0] code,
                                  logic signed [VB-1:0] qa, ma, da,
                                  logic signed [VB-1:0] qb, mb, db,
                                  logic sv, logic lst);
    request_t r;
    r.code = code;
    r.query_a = qa; r.min_a = ma; r.diff_a = da;
    r.query_b = qb; r.min_b = mb; r.diff_b = db;
    r.second_valid = sv;
    r.last = lst;
    return r;
  endfunction

  // Value mix: extremes and zero often, small values, then anything
  function automatic logic signed [VB-1:0] rand_value();
    case ($urandom_range(9))
      0: return V_MAX;
      1: return V_MIN;
      2: return '0;
      3, 4: return VB'($signed($urandom_range(200)) - 100);
      default: return VB'($urandom);
    endcase
  endfunction

  // Inputs change on the falling edge; acceptance is seen on the rising edge
  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    in_code_byte    <= r.code;
    in_query_first  <= r.query_a;
    in_min_first    <= r.min_a;
    in_diff_first   <= r.diff_a;
    in_query_second <= r.query_b;
    in_min_second   <= r.min_b;
    in_diff_second  <= r.diff_b;
    in_second_valid <= r.second_valid;
    in_last         <= r.last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(r);
  endtask

  // Random vectors, mostly short, some long; odd tails more likely on the last byte
  task automatic send_random_vectors(input int n_items);
    int       sent;
    int       len;
    request_t r;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        r = mk(8'($urandom), rand_value(), rand_value(), rand_value(),
               rand_value(), rand_value(), rand_value(), 1'b1, i == len - 1);
        r.second_valid = r.last ? ($urandom_range(3) != 0) : ($urandom_range(9) != 0);
        send_request(r);
      end
      sent += len;
    end
  endtask

  // Stop offering, then wait for every owed distance
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
  endtask

  // Receiver: random pop, plus one long hold-off when asked for
  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk);
      if (pop && !empty) sb.check_distance(out_distance);
    end
  end

  initial begin
    request_t r;
    sb = new();
    tx_idle_pct     = 37;
    rx_idle_pct     = 86;
    hold_off_req    = 1'b0;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_code_byte    = '0;
    in_query_first  = '0;
    in_min_first    = '0;
    in_diff_first   = '0;
    in_query_second = '0;
    in_min_second   = '0;
    in_diff_second  = '0;
    in_second_valid = 1'b0;
    in_last         = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero distance, largest gaps both ways, negative ranges,
    // truncation of the /15, odd tails, short and multi-byte vectors
    send_request(mk(8'h00, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_request(mk(8'hFF, V_MAX, V_MIN, V_MIN, V_MAX, V_MIN, V_MIN, 1'b1, 1'b1));
    send_request(mk(8'hF0, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MAX, 1'b1, 1'b1));
    send_request(mk(8'h0F, 0, 0, V_MIN, 0, 0, V_MIN, 1'b1, 1'b1));
    send_request(mk(8'hFF, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX, V_MIN, 1'b1, 1'b1));
    send_request(mk(8'hA7, 0, 0, 7, 0, 0, -7, 1'b1, 1'b0));
    send_request(mk(8'h7A, 3, -2, -7, -3, 2, 7, 1'b1, 1'b1));
    send_request(mk(8'h3C, 100, 5, 30, V_MAX, V_MIN, V_MIN, 1'b0, 1'b1));
    send_request(mk(8'h12, 1, 0, 15, -1, 0, -15, 1'b1, 1'b0));
    send_request(mk(8'h34, 24'h01_0000, 0, 24'h00_F000, 0, 1, 2, 1'b1, 1'b0));
    send_request(mk(8'h56, -5, 9, 11, V_MAX, V_MAX, V_MAX, 1'b0, 1'b1));
    send_request(mk(8'h80, 1, 0, 15, 0, 0, 0, 1'b1, 1'b1));
    send_request(mk(8'hFF, V_MAX, V_MIN, V_MIN, 0, 0, 0, 1'b0, 1'b0));
    send_request(mk(8'h11, V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN, 1'b1, 1'b1));
    send_request(mk(8'hE1, 0, 0, 14, 0, 0, 1, 1'b1, 1'b1));
    send_request(mk(8'h55, V_MAX, 0, 0, 0, V_MAX, 0, 1'b1, 1'b1));

    send_random_vectors(225);
    drain();

    tx_idle_pct = 86;
    rx_idle_pct = 37;
    send_random_vectors(225);
    drain();

    // Back-pressure: single-byte vectors while the receiver holds off
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      r = mk(8'($urandom), rand_value(), rand_value(), rand_value(),
             rand_value(), rand_value(), rand_value(), 1'($urandom), 1'b1);
      send_request(r);
    end
    drain();

    send_random_vectors(225);
    drain();

    send_request(mk(8'h9C, 77, -3, 450, -12, 8, -90, 1'b1, 1'b1));

    @(negedge clk);
    push <= 1'b0;
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("int4_dequant_l2_distance_unit test passed");
    end else begin
      $display("int4_dequant_l2_distance_unit test failed");
    end
    $finish;
  end

endmodule
